>>> src/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by every module under src but sobel_ram; depends on nothing.
package sobel_pkg;

    localparam int IMAGE_WIDTH  = 320;
    localparam int IMAGE_HEIGHT = 240;

    localparam int PIX_W = 8;
    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);

    // Gradients: each weighted column or row sum is below 4*256, so 10 bits,
    // and their difference needs one more bit for the sign.
    localparam int SUM_W  = PIX_W + 2;
    localparam int GRAD_W = SUM_W + 1;
    localparam int MAG_W  = SUM_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = '0;
    localparam logic [PIX_W-1:0]     THRESHOLD_RESET    = 8'd16;

    localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
    localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;

    // One column of the 3x3 window, top row first.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // Both line buffers share one memory word: the row two above in the
    // upper byte, the row one above in the lower byte.
    typedef struct packed {
        logic [PIX_W-1:0] two_above;
        logic [PIX_W-1:0] one_above;
    } line_word_t;

endpackage

>>> src/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the line buffers.
module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sobel_cell.sv
// One column cell of the 3x3 window: holds three pixels and passes them on.
// Depends on sobel_pkg.
module sobel_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  sobel_pkg::col_t   col_in,
    output sobel_pkg::col_t   col_out
);

    sobel_pkg::col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> src/sobel_grad.sv
// Gradient and threshold unit: registers gx and gy, then forms the magnitude
// and compares it against the threshold. Depends on sobel_pkg.
module sobel_grad (
    input  logic                          clk,
    input  logic                          en,
    input  sobel_pkg::col_t               left,
    input  sobel_pkg::col_t               centre,
    input  sobel_pkg::col_t               right,
    input  logic [sobel_pkg::PIX_W-1:0]   threshold,
    output logic                          is_edge
);

    localparam int SUM_W  = sobel_pkg::SUM_W;
    localparam int GRAD_W = sobel_pkg::GRAD_W;
    localparam int MAG_W  = sobel_pkg::MAG_W;

    logic [SUM_W-1:0]         sum_right;
    logic [SUM_W-1:0]         sum_left;
    logic [SUM_W-1:0]         sum_bot;
    logic [SUM_W-1:0]         sum_top;
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic [SUM_W-1:0]         abs_gx;
    logic [SUM_W-1:0]         abs_gy;
    logic [MAG_W-1:0]         mag_sum;
    logic [MAG_W-3:0]         mag;

    always_comb
    begin
        sum_right = SUM_W'(right.top) + SUM_W'({right.mid, 1'b0})
                  + SUM_W'(right.bot);
        sum_left  = SUM_W'(left.top) + SUM_W'({left.mid, 1'b0})
                  + SUM_W'(left.bot);
        sum_bot   = SUM_W'(left.bot) + SUM_W'({centre.bot, 1'b0})
                  + SUM_W'(right.bot);
        sum_top   = SUM_W'(left.top) + SUM_W'({centre.top, 1'b0})
                  + SUM_W'(right.top);
        gx_next   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        gy_next   = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    always_comb
    begin
        abs_gx  = gx_reg[GRAD_W-1] ? SUM_W'(-gx_reg) : gx_reg[SUM_W-1:0];
        abs_gy  = gy_reg[GRAD_W-1] ? SUM_W'(-gy_reg) : gy_reg[SUM_W-1:0];
        mag_sum = MAG_W'(abs_gx) + MAG_W'(abs_gy);
        mag     = mag_sum[MAG_W-1:2];
        is_edge = mag > (MAG_W-2)'(threshold);
    end

endmodule

>>> src/sobel_edge_threshold.sv
// Streaming 3x3 Sobel edge detector with threshold: line-buffer memory, a
// chain of three window column cells, gradient unit and output skid stage.
// A result passes stage 1, the window cells, the gradient and output registers.
// Throughput: one pixel per cycle while the skid is empty, set by one read and
// one write of the line buffer memory per cycle. Reset clears counters, pipeline
// and threshold (16), not the line buffers: the first two rows give no result.
module sobel_edge_threshold (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sobel_pkg::PIX_W-1:0]         in_pixel,
    input  logic                                start_of_frame,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sobel_pkg::PIX_W-1:0]         out_pixel,
    output logic                                frame_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sobel_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sobel_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sobel_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int PIX_W = sobel_pkg::PIX_W;
    localparam int COL_W = sobel_pkg::COL_W;
    localparam int ROW_W = sobel_pkg::ROW_W;
    localparam int LW    = $bits(sobel_pkg::line_word_t);

    // Configuration
    logic [PIX_W-1:0] thresh_reg;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[sobel_pkg::APB_ADDR_W-1:2] == sobel_pkg::REG_EDGE_THRESHOLD;
    assign prdata  = cfg_hit ? sobel_pkg::APB_DATA_W'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= sobel_pkg::THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            thresh_reg <= pwdata[PIX_W-1:0];
        end
    end

    // Pipeline control: everything advances together unless the skid is full.
    logic adv;
    logic accept;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && adv;

    // Position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             col_wrap;
    logic             row_wrap;

    always_comb
    begin
        col_cur  = start_of_frame ? '0 : col_reg;
        row_cur  = start_of_frame ? '0 : row_reg;
        col_wrap = col_cur == COL_W'(sobel_pkg::IMAGE_WIDTH - 1);
        row_wrap = row_cur == ROW_W'(sobel_pkg::IMAGE_HEIGHT - 1);
        col_next = col_wrap ? '0 : col_cur + COL_W'(1);
        if (!col_wrap)
        begin
            row_next = row_cur;
        end
        else
        begin
            row_next = row_wrap ? '0 : row_cur + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line buffer read returns; the memory is written back here.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             byp_reg;
    logic [LW-1:0]    byp_data_reg;

    sobel_pkg::line_word_t ram_rdata;
    sobel_pkg::line_word_t line_rd;
    sobel_pkg::line_word_t line_wr;
    logic                  ram_we;

    assign ram_we            = s1_valid_reg && adv;
    assign line_rd           = byp_reg ? sobel_pkg::line_word_t'(byp_data_reg) : ram_rdata;
    assign line_wr.two_above = line_rd.one_above;
    assign line_wr.one_above = s1_pix_reg;

    sobel_ram #(
        .WIDTH (LW),
        .DEPTH (sobel_pkg::IMAGE_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (line_wr),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    // A restart of the frame can read the entry that is being written back
    // in the same cycle; the write data is forwarded in that case.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= in_pixel;
            s1_col_reg   <= col_cur;
            s1_emit_reg  <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
            s1_last_reg  <= row_wrap && col_wrap;
            byp_reg      <= ram_we && (s1_col_reg == col_cur);
            byp_data_reg <= line_wr;
        end
    end

    // Window: chain of column cells, newest on the right.
    sobel_pkg::col_t new_col;
    sobel_pkg::col_t win_left;
    sobel_pkg::col_t win_centre;
    sobel_pkg::col_t win_right;
    logic            win_en;

    assign win_en      = s1_valid_reg && adv;
    assign new_col.top = line_rd.two_above;
    assign new_col.mid = line_rd.one_above;
    assign new_col.bot = s1_pix_reg;

    sobel_cell u_cell_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (win_en),
        .col_in  (new_col),
        .col_out (win_right)
    );

    sobel_cell u_cell_centre (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (win_en),
        .col_in  (win_right),
        .col_out (win_centre)
    );

    sobel_cell u_cell_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (win_en),
        .col_in  (win_centre),
        .col_out (win_left)
    );

    // Stages 2 and 3: gradients, then magnitude and threshold.
    logic s2_valid_reg;
    logic s2_last_reg;
    logic s3_valid_reg;
    logic s3_last_reg;
    logic is_edge;

    sobel_grad u_grad (
        .clk       (clk),
        .en        (adv),
        .left      (win_left),
        .centre    (win_centre),
        .right     (win_right),
        .threshold (thresh_reg),
        .is_edge   (is_edge)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Output register with a one-entry skid behind it.
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] skid_pixel_reg;
    logic             skid_last_reg;
    logic             produce;
    logic             out_free;
    logic [PIX_W-1:0] res_pixel;

    assign produce   = adv && s3_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign res_pixel = is_edge ? sobel_pkg::PIX_EDGE : sobel_pkg::PIX_FLAT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_pixel_reg <= skid_pixel_reg;
                out_last_reg  <= skid_last_reg;
            end
            else
            begin
                out_pixel_reg <= res_pixel;
                out_last_reg  <= s3_last_reg;
            end
        end
        else if (produce)
        begin
            skid_pixel_reg <= res_pixel;
            skid_last_reg  <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign frame_last = out_last_reg;

    // The skid only ever holds a request while the output register is full.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while the output register is empty");

    // The bottom-right pixel of a frame wraps both counters to zero.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_wrap && col_wrap) |=> (col_reg == '0 && row_reg == '0))
        else $error("position counters did not wrap at the end of the frame");

    // While the skid is full no pixel is taken, so the position stays put.
    a_stall_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position counters moved while the input was stalled");

endmodule
